// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the SD card SPI host RTL.
// Needs nothing else; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SDH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define SDH_NEVER(lbl, clk, rst, cond, msg) \
   `SDH_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

// ----- rtl/core/sdh_pkg.sv -----
// Types, constants and frame helpers for the SD card SPI host sequencer.
// No dependencies; the other .sv files in rtl/core use it by scoped names.
`default_nettype none

package sdh_pkg;

   localparam int BLOCK_BYTES = 512;
   localparam int CSD_LEN     = 16;
   localparam int IDX_W       = $clog2(BLOCK_BYTES + 1);
   localparam int CSD_IDX_W   = $clog2(CSD_LEN);
   localparam int ADDR_W      = 3;

   // item kinds
   localparam logic [1:0] KIND_START   = 2'd0;
   localparam logic [1:0] KIND_CARD    = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD = 2'd2;

   // operations
   localparam logic [2:0] OP_INIT  = 3'd0;
   localparam logic [2:0] OP_READ  = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_MULTI = 3'd3;
   localparam logic [2:0] OP_CAP   = 3'd4;

   // command codes
   localparam logic [7:0] CMD_GO_IDLE   = 8'd0;
   localparam logic [7:0] CMD_SEND_OP   = 8'd1;
   localparam logic [7:0] CMD_CRC_ON    = 8'd59;
   localparam logic [7:0] CMD_BLOCKLEN  = 8'd16;
   localparam logic [7:0] CMD_RD_SINGLE = 8'd17;
   localparam logic [7:0] CMD_WR_SINGLE = 8'd24;
   localparam logic [7:0] CMD_WR_MULTI  = 8'd25;
   localparam logic [7:0] CMD_SEND_CSD  = 8'd9;

   // link bytes and tokens
   localparam logic [7:0] BYTE_IDLE     = 8'hFF;
   localparam logic [7:0] CMD_PREFIX    = 8'h40;
   localparam logic [7:0] FRAME_CRC     = 8'h95;
   localparam logic [7:0] TOK_SINGLE    = 8'hFE;
   localparam logic [7:0] TOK_MULTI     = 8'hFC;
   localparam logic [7:0] TOK_STOP      = 8'hFD;
   localparam logic [7:0] DRESP_MASK    = 8'h1F;
   localparam logic [7:0] DRESP_OK      = 8'h05;
   localparam logic [7:0] R1_IDLE       = 8'h01;
   localparam logic [7:0] R1_READY      = 8'h00;
   localparam logic [7:0] BYTE_BUSY     = 8'h00;

   // CSR map
   localparam logic [ADDR_W-1:0] REG_WAIT_LIMIT = 3'd0;
   localparam logic [7:0]        WAIT_LIMIT_RST = 8'd100;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  op;
      logic [22:0] sector;
      logic [7:0]  block_count;
      logic [7:0]  miso_byte;
      logic [7:0]  payload_byte;
   } req_type;

   typedef struct packed {
      logic        send_valid;
      logic [7:0]  mosi_byte;
      logic        need_payload;
      logic        read_valid;
      logic [7:0]  read_byte;
      logic        fast_clock;
      logic [31:0] capacity;
      logic        done_res;
   } rsp_type;

   typedef struct packed {
      logic                 en;
      logic [CSD_IDX_W-1:0] idx;
      logic [7:0]           data;
   } csd_wr_type;

   // init command for each init stage
   function automatic logic [7:0] init_cmd(input logic [1:0] stage);
      logic [7:0] c;
      case (stage)
         2'd0:    c = CMD_GO_IDLE;
         2'd1:    c = CMD_SEND_OP;
         2'd2:    c = CMD_CRC_ON;
         default: c = CMD_BLOCKLEN;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sdh_csd.sv -----
// CSD register store and capacity decode for the SD card SPI host.
// Depends on sdh_pkg.
`default_nettype none

module sdh_csd (
   input  wire logic               clock,
   input  wire sdh_pkg::csd_wr_type wr,
   output logic [31:0]             capacity
);

   logic [7:0]  csd_ff [sdh_pkg::CSD_LEN];
   logic [11:0] c_size;
   logic [12:0] c_size_p1;
   logic [2:0]  mult;
   logic [3:0]  bl_len;
   logic [4:0]  shamt;

   // store CSD bytes as they arrive
   always_ff @(posedge clock) begin
      if (wr.en) begin
         csd_ff[wr.idx] <= wr.data;
      end
   end

   // decode CSD v1 size fields, wrap at 32 bits
   always_comb begin
      c_size    = {csd_ff[6][1:0], csd_ff[7], csd_ff[8][7:6]};
      c_size_p1 = {1'b0, c_size} + 13'd1;
      mult      = {csd_ff[9][1:0], csd_ff[10][7]};
      bl_len    = csd_ff[5][3:0];
      shamt     = 5'(mult) + 5'd2 + 5'(bl_len);
      capacity  = {19'b0, c_size_p1} << shamt;
   end

endmodule

`default_nettype wire

// ----- rtl/core/sdh_core.sv -----
// Command and data sequencer for the SD card SPI host: one item per firing.
// Depends on sdh_pkg; the CSD store lives in sdh_csd.
`default_nettype none

module sdh_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire sdh_pkg::req_type    item,
   input  wire logic [7:0]          wait_limit,
   input  wire logic [31:0]         capacity,
   output logic                     has_res,
   output sdh_pkg::rsp_type         res,
   output sdh_pkg::csd_wr_type      csd_wr
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_CMD, PH_POLL, PH_GAP, PH_WTOKEN, PH_WPAYREQ, PH_WPAYSENT,
      PH_DRESP, PH_BUSY, PH_STOP, PH_STOPBUSY, PH_TOKWAIT, PH_RDATA, PH_TRAIL
   } phase_type;

   localparam int IW = sdh_pkg::IDX_W;

   phase_type         phase_ff, phase_in;
   logic [2:0]        op_ff, op_in;
   logic [1:0]        stage_ff, stage_in;
   logic [22:0]       sector_ff, sector_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [7:0]        poll_ff, poll_in;
   logic [8:0]        blocks_ff, blocks_in;
   logic              fast_ff, fast_in;

   logic [IW-1:0]     idx_inc;
   logic [7:0]        poll_inc;
   logic [7:0]        lim;
   logic [8:0]        blocks_dec;
   logic [7:0]        code;
   logic [31:0]       arg;
   logic [7:0]        r;
   logic              r1_ok;
   logic [7:0]        frame_next;

   // command code and argument of the current frame
   always_comb begin
      unique case (op_ff)
         sdh_pkg::OP_INIT:  code = sdh_pkg::init_cmd(stage_ff);
         sdh_pkg::OP_READ:  code = sdh_pkg::CMD_RD_SINGLE;
         sdh_pkg::OP_WRITE: code = sdh_pkg::CMD_WR_SINGLE;
         sdh_pkg::OP_MULTI: code = sdh_pkg::CMD_WR_MULTI;
         default:           code = sdh_pkg::CMD_SEND_CSD;
      endcase
      if (op_ff == sdh_pkg::OP_INIT) begin
         arg = (stage_ff == 2'd3) ? 32'(sdh_pkg::BLOCK_BYTES) : 32'd0;
      end else if (op_ff == sdh_pkg::OP_READ || op_ff == sdh_pkg::OP_WRITE ||
                   op_ff == sdh_pkg::OP_MULTI) begin
         arg = 32'(sector_ff) * 32'(sdh_pkg::BLOCK_BYTES);
      end else begin
         arg = 32'd0;
      end
      idx_inc = idx_ff + IW'(1);
      case (idx_inc)
         IW'(1):  frame_next = code | sdh_pkg::CMD_PREFIX;
         IW'(2):  frame_next = arg[31:24];
         IW'(3):  frame_next = arg[23:16];
         IW'(4):  frame_next = arg[15:8];
         IW'(5):  frame_next = arg[7:0];
         default: frame_next = sdh_pkg::FRAME_CRC;
      endcase
   end

   // one sequencing step for the held item
   always_comb begin
      r          = item.miso_byte;
      poll_inc   = poll_ff + 8'd1;
      lim        = (wait_limit == 8'd0) ? 8'd1 : wait_limit;
      blocks_dec = (blocks_ff != 9'd0) ? blocks_ff - 9'd1 : 9'd0;
      r1_ok      = (op_ff == sdh_pkg::OP_INIT && stage_ff == 2'd0) ?
                   (r == sdh_pkg::R1_IDLE) : (r == sdh_pkg::R1_READY);

      phase_in  = phase_ff;
      op_in     = op_ff;
      stage_in  = stage_ff;
      sector_in = sector_ff;
      idx_in    = idx_ff;
      poll_in   = poll_ff;
      blocks_in = blocks_ff;
      fast_in   = fast_ff;
      has_res   = 1'b0;
      res       = '0;
      csd_wr    = '0;
      csd_wr.idx  = idx_ff[sdh_pkg::CSD_IDX_W-1:0];
      csd_wr.data = r;

      unique case (item.kind)
         sdh_pkg::KIND_START: begin
            if (phase_ff == PH_IDLE && item.op <= sdh_pkg::OP_CAP) begin
               op_in     = item.op;
               sector_in = item.sector;
               blocks_in = (item.block_count == 8'd0) ? 9'd256 : 9'(item.block_count);
               if (item.op == sdh_pkg::OP_INIT) begin
                  stage_in = 2'd0;
                  fast_in  = 1'b0;
               end
               phase_in       = PH_CMD;
               idx_in         = '0;
               res.send_valid = 1'b1;
               res.mosi_byte  = sdh_pkg::BYTE_IDLE;
               has_res        = 1'b1;
            end
         end
         sdh_pkg::KIND_PAYLOAD: begin
            if (phase_ff == PH_WPAYREQ) begin
               phase_in       = PH_WPAYSENT;
               res.send_valid = 1'b1;
               res.mosi_byte  = item.payload_byte;
               has_res        = 1'b1;
            end
         end
         sdh_pkg::KIND_CARD: begin
            has_res = 1'b1;
            unique case (phase_ff)
               PH_CMD: begin
                  res.send_valid = 1'b1;
                  if (idx_ff < IW'(6)) begin
                     idx_in        = idx_inc;
                     res.mosi_byte = frame_next;
                  end else begin
                     phase_in      = PH_POLL;
                     poll_in       = 8'd0;
                     res.mosi_byte = sdh_pkg::BYTE_IDLE;
                  end
               end
               PH_POLL: begin
                  poll_in = poll_inc;
                  res.send_valid = 1'b1;
                  res.mosi_byte  = sdh_pkg::BYTE_IDLE;
                  if (r == sdh_pkg::BYTE_IDLE && poll_inc < lim) begin
                     // keep polling
                  end else if (!r1_ok) begin
                     phase_in = PH_CMD;
                     idx_in   = '0;
                  end else if (op_ff == sdh_pkg::OP_INIT) begin
                     if (stage_ff == 2'd1) begin
                        fast_in = 1'b1;
                     end
                     if (stage_ff != 2'd3) begin
                        stage_in = stage_ff + 2'd1;
                        phase_in = PH_CMD;
                        idx_in   = '0;
                     end else begin
                        phase_in       = PH_IDLE;
                        res.send_valid = 1'b0;
                        res.mosi_byte  = 8'd0;
                        res.done_res   = 1'b1;
                     end
                  end else if (op_ff == sdh_pkg::OP_READ || op_ff == sdh_pkg::OP_CAP) begin
                     phase_in = PH_TOKWAIT;
                  end else begin
                     phase_in = PH_GAP;
                     idx_in   = '0;
                  end
               end
               PH_GAP: begin
                  idx_in = idx_inc;
                  res.send_valid = 1'b1;
                  if (idx_inc < IW'(3)) begin
                     res.mosi_byte = sdh_pkg::BYTE_IDLE;
                  end else begin
                     phase_in      = PH_WTOKEN;
                     res.mosi_byte = (op_ff == sdh_pkg::OP_WRITE) ?
                                     sdh_pkg::TOK_SINGLE : sdh_pkg::TOK_MULTI;
                  end
               end
               PH_WTOKEN: begin
                  phase_in         = PH_WPAYREQ;
                  idx_in           = '0;
                  res.need_payload = 1'b1;
               end
               PH_WPAYSENT: begin
                  idx_in = idx_inc;
                  if (idx_inc < IW'(sdh_pkg::BLOCK_BYTES)) begin
                     phase_in         = PH_WPAYREQ;
                     res.need_payload = 1'b1;
                  end else begin
                     phase_in       = PH_DRESP;
                     res.send_valid = 1'b1;
                     res.mosi_byte  = sdh_pkg::BYTE_IDLE;
                  end
               end
               PH_DRESP: begin
                  if ((r & sdh_pkg::DRESP_MASK) == sdh_pkg::DRESP_OK) begin
                     phase_in = PH_BUSY;
                  end
                  res.send_valid = 1'b1;
                  res.mosi_byte  = sdh_pkg::BYTE_IDLE;
               end
               PH_BUSY: begin
                  if (r == sdh_pkg::BYTE_BUSY) begin
                     res.send_valid = 1'b1;
                     res.mosi_byte  = sdh_pkg::BYTE_IDLE;
                  end else if (op_ff == sdh_pkg::OP_WRITE) begin
                     phase_in     = PH_IDLE;
                     res.done_res = 1'b1;
                  end else begin
                     blocks_in      = blocks_dec;
                     res.send_valid = 1'b1;
                     if (blocks_dec != 9'd0) begin
                        phase_in      = PH_WTOKEN;
                        res.mosi_byte = sdh_pkg::TOK_MULTI;
                     end else begin
                        phase_in      = PH_STOP;
                        res.mosi_byte = sdh_pkg::TOK_STOP;
                     end
                  end
               end
               PH_STOP: begin
                  phase_in       = PH_STOPBUSY;
                  res.send_valid = 1'b1;
                  res.mosi_byte  = sdh_pkg::BYTE_IDLE;
               end
               PH_STOPBUSY: begin
                  if (r == sdh_pkg::BYTE_BUSY) begin
                     res.send_valid = 1'b1;
                     res.mosi_byte  = sdh_pkg::BYTE_IDLE;
                  end else begin
                     phase_in     = PH_IDLE;
                     res.done_res = 1'b1;
                  end
               end
               PH_TOKWAIT: begin
                  if (r == sdh_pkg::TOK_SINGLE) begin
                     phase_in = PH_RDATA;
                     idx_in   = '0;
                  end
                  res.send_valid = 1'b1;
                  res.mosi_byte  = sdh_pkg::BYTE_IDLE;
               end
               PH_RDATA: begin
                  res.send_valid = 1'b1;
                  res.mosi_byte  = sdh_pkg::BYTE_IDLE;
                  idx_in         = idx_inc;
                  if (op_ff == sdh_pkg::OP_READ) begin
                     res.read_valid = 1'b1;
                     res.read_byte  = r;
                     if (idx_inc >= IW'(sdh_pkg::BLOCK_BYTES)) begin
                        phase_in = PH_TRAIL;
                        idx_in   = '0;
                     end
                  end else begin
                     csd_wr.en = (idx_ff < IW'(sdh_pkg::CSD_LEN));
                     if (idx_inc >= IW'(sdh_pkg::CSD_LEN)) begin
                        phase_in = PH_TRAIL;
                        idx_in   = '0;
                     end
                  end
               end
               PH_TRAIL: begin
                  idx_in = idx_inc;
                  if (idx_inc < ((op_ff == sdh_pkg::OP_READ) ? IW'(3) : IW'(10))) begin
                     res.send_valid = 1'b1;
                     res.mosi_byte  = sdh_pkg::BYTE_IDLE;
                  end else begin
                     phase_in     = PH_IDLE;
                     res.done_res = 1'b1;
                     if (op_ff == sdh_pkg::OP_CAP) begin
                        res.capacity = capacity;
                     end
                  end
               end
               default: begin
                  has_res = 1'b0;
               end
            endcase
         end
         default: begin
            has_res = 1'b0;
         end
      endcase

      // drop every update when no item fires
      if (!fire) begin
         has_res   = 1'b0;
         csd_wr.en = 1'b0;
      end
      res.fast_clock = fast_in;
   end

   // hold sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         op_ff     <= '0;
         stage_ff  <= '0;
         sector_ff <= '0;
         idx_ff    <= '0;
         poll_ff   <= '0;
         blocks_ff <= '0;
         fast_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         op_ff     <= op_in;
         stage_ff  <= stage_in;
         sector_ff <= sector_in;
         idx_ff    <= idx_in;
         poll_ff   <= poll_in;
         blocks_ff <= blocks_in;
         fast_ff   <= fast_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/sd_card_spi_host_sequencer.sv -----
// Top level of the SD card SPI-mode host sequencer: item register, result
// register and CSR port. Depends on sdh_pkg, sdh_core, sdh_csd, assert_macros.svh.
//
//   channel | ports      | beat
//   --------+------------+--------------------------------------------
//   request | req_*      | one item: start, card byte or payload byte
//   result  | rsp_*      | one result for an item that causes one
//   csr     | csr_*      | APB write/read of response_wait_limit
//
// An item is taken into the item register and sequenced when the output is free;
// its result then loads into the result register, which drives rsp_valid.
// One item per cycle is sustained while no result is stalled; the sequencer
// state update sets the loop.
// reset is synchronous and clears all control state; the CSD store has none.
// A stalled result holds in place and stalls the item register behind it.
`default_nettype none
`include "assert_macros.svh"

module sd_card_spi_host_sequencer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire sdh_pkg::req_type            req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output sdh_pkg::rsp_type                 rsp_data,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [sdh_pkg::ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   sdh_pkg::req_type    item_ff;
   logic                item_vld_ff, item_vld_in;
   sdh_pkg::rsp_type    rsp_ff;
   logic                rsp_vld_ff;
   logic [7:0]          limit_ff;
   logic                out_free;
   logic                fire;
   logic                has_res;
   sdh_pkg::rsp_type    res;
   sdh_pkg::csd_wr_type csd_wr;
   logic [31:0]         capacity;

   // handshake glue
   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign fire      = item_vld_ff && out_free;
   assign req_stall = item_vld_ff && !out_free;
   assign item_vld_in = (req_valid && !req_stall) ? 1'b1 : (fire ? 1'b0 : item_vld_ff);

   // CSR access
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == sdh_pkg::REG_WAIT_LIMIT) ? {24'b0, limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= sdh_pkg::WAIT_LIMIT_RST;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == sdh_pkg::REG_WAIT_LIMIT) begin
         limit_ff <= csr_pwdata[7:0];
      end
   end

   // item register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else begin
         item_vld_ff <= item_vld_in;
      end
      if (req_valid && !req_stall) begin
         item_ff <= req_data;
      end
   end

   sdh_core u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (item_ff),
      .wait_limit (limit_ff),
      .capacity   (capacity),
      .has_res    (has_res),
      .res        (res),
      .csd_wr     (csd_wr)
   );

   sdh_csd u_csd (
      .clock    (clock),
      .wr       (csd_wr),
      .capacity (capacity)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_free) begin
         rsp_vld_ff <= fire && has_res;
      end
      if (out_free && fire && has_res) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   `SDH_NEVER(a_done_no_send, clock, reset, rsp_vld_ff && rsp_ff.done_res && rsp_ff.send_valid, "done result also asks for an exchange")
   `SDH_NEVER(a_cap_only_done, clock, reset, rsp_vld_ff && !rsp_ff.done_res && rsp_ff.capacity != 32'd0, "capacity shown off the done result")
   `SDH_NEVER(a_stall_needs_item, clock, reset, req_stall && !item_vld_ff, "input stalled with empty item register")
   `SDH_ASSERT(a_stall_holds_result, clock, reset, (rsp_vld_ff && rsp_stall) |=> (rsp_vld_ff && $stable(rsp_ff)), "stalled result lost")

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for the SD card SPI host sequencer: random and directed operations
// checked beat by beat against a predictor kept inside this file.
// Depends on sdh_pkg and the sd_card_spi_host_sequencer top level.
`timescale 1ns / 1ps

module tb;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int RANDOM_ITEMS   = 30;
   localparam int REQ_W          = $bits(sdh_pkg::req_type);

   typedef enum int {
      ST_IDLE, ST_CMD, ST_POLL, ST_GAP, ST_WTOKEN, ST_WPAYREQ, ST_WPAYSENT,
      ST_DRESP, ST_BUSY, ST_STOP, ST_STOPBUSY, ST_TOKWAIT, ST_RDATA, ST_TRAIL
   } seq_state_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   sdh_pkg::req_type           req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   sdh_pkg::rsp_type           rsp_data;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [sdh_pkg::ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]                csr_pwdata = '0;
   logic [31:0]                csr_prdata;
   logic                       csr_pready;

   sd_card_spi_host_sequencer DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted sequencer state
   seq_state_type seq_phase = ST_IDLE;
   logic [2:0]    seq_op = '0;
   logic [1:0]    seq_stage = '0;
   logic [22:0]   seq_sector = '0;
   int            seq_index = 0;
   int            seq_polls = 0;
   int            seq_blocks = 0;
   logic [7:0]    csd_shadow [sdh_pkg::CSD_LEN];
   logic          fast_sel = 1'b0;
   logic [7:0]    wait_limit = sdh_pkg::WAIT_LIMIT_RST;

   sdh_pkg::rsp_type expected_beats [$];
   int               fail_count = 0;
   int               items_sent = 0;
   int               idle_pct = 0;
   int               stall_pct = 0;
   int               noise_pct = 0;
   int               quiet_cycles = 0;

   function automatic logic [7:0] frame_byte(input int i);
      logic [31:0] arg;
      logic [7:0]  code;
      arg = 32'd0;
      case (seq_op)
         sdh_pkg::OP_INIT: begin
            arg = (seq_stage == 2'd3) ? sdh_pkg::BLOCK_BYTES : 0;
            case (seq_stage)
               2'd0:    code = sdh_pkg::CMD_GO_IDLE;
               2'd1:    code = sdh_pkg::CMD_SEND_OP;
               2'd2:    code = sdh_pkg::CMD_CRC_ON;
               default: code = sdh_pkg::CMD_BLOCKLEN;
            endcase
         end
         sdh_pkg::OP_READ: begin
            code = sdh_pkg::CMD_RD_SINGLE; arg = {seq_sector, 9'd0};
         end
         sdh_pkg::OP_WRITE: begin
            code = sdh_pkg::CMD_WR_SINGLE; arg = {seq_sector, 9'd0};
         end
         sdh_pkg::OP_MULTI: begin
            code = sdh_pkg::CMD_WR_MULTI; arg = {seq_sector, 9'd0};
         end
         default: code = sdh_pkg::CMD_SEND_CSD;
      endcase
      case (i)
         0:       return sdh_pkg::BYTE_IDLE;
         1:       return code | sdh_pkg::CMD_PREFIX;
         2:       return arg[31:24];
         3:       return arg[23:16];
         4:       return arg[15:8];
         5:       return arg[7:0];
         default: return sdh_pkg::FRAME_CRC;
      endcase
   endfunction

   function automatic logic [31:0] csd_capacity();
      logic [11:0] c_size;
      logic [2:0]  mult;
      logic [3:0]  bl_len;
      logic [63:0] cap;
      c_size = {csd_shadow[6][1:0], csd_shadow[7], csd_shadow[8][7:6]};
      mult   = {csd_shadow[9][1:0], csd_shadow[10][7]};
      bl_len = csd_shadow[5][3:0];
      cap = (64'(c_size) + 64'd1) << (32'(mult) + 32'd2);
      cap = cap << bl_len;
      return cap[31:0];
   endfunction

   // work out the result of one accepted item; returns 0 when it causes none
   function automatic bit predict_step(input sdh_pkg::req_type it,
                                       output sdh_pkg::rsp_type r);
      int         lim;
      logic [7:0] card;
      card = it.miso_byte;
      r = '0;
      if (it.kind == sdh_pkg::KIND_START) begin
         if (seq_phase != ST_IDLE || it.op > sdh_pkg::OP_CAP) return 0;
         seq_op = it.op;
         seq_sector = it.sector;
         seq_blocks = (it.block_count == 0) ? 256 : it.block_count;
         if (it.op == sdh_pkg::OP_INIT) begin
            seq_stage = 2'd0;
            fast_sel = 1'b0;
         end
         seq_phase = ST_CMD; seq_index = 0;
         r.send_valid = 1'b1; r.mosi_byte = frame_byte(0);
      end else if (it.kind == sdh_pkg::KIND_PAYLOAD) begin
         if (seq_phase != ST_WPAYREQ) return 0;
         seq_phase = ST_WPAYSENT;
         r.send_valid = 1'b1; r.mosi_byte = it.payload_byte;
      end else if (it.kind == sdh_pkg::KIND_CARD) begin
         case (seq_phase)
            ST_CMD: begin
               r.send_valid = 1'b1;
               if (seq_index < 6) begin
                  seq_index++;
                  r.mosi_byte = frame_byte(seq_index);
               end else begin
                  seq_phase = ST_POLL; seq_polls = 0; r.mosi_byte = sdh_pkg::BYTE_IDLE;
               end
            end
            ST_POLL: begin
               lim = (wait_limit == 0) ? 1 : wait_limit;
               seq_polls++;
               r.send_valid = 1'b1; r.mosi_byte = sdh_pkg::BYTE_IDLE;
               if (card == sdh_pkg::BYTE_IDLE && seq_polls < lim) begin
               end else if (card != ((seq_op == sdh_pkg::OP_INIT && seq_stage == 0) ?
                                     sdh_pkg::R1_IDLE : sdh_pkg::R1_READY)) begin
                  seq_phase = ST_CMD; seq_index = 0; r.mosi_byte = frame_byte(0);
               end else if (seq_op == sdh_pkg::OP_INIT) begin
                  if (seq_stage == 1) fast_sel = 1'b1;
                  if (seq_stage < 3) begin
                     seq_stage++;
                     seq_phase = ST_CMD; seq_index = 0; r.mosi_byte = frame_byte(0);
                  end else begin
                     seq_phase = ST_IDLE; r.send_valid = 1'b0; r.mosi_byte = 8'd0;
                     r.done_res = 1'b1;
                  end
               end else if (seq_op == sdh_pkg::OP_READ || seq_op == sdh_pkg::OP_CAP) begin
                  seq_phase = ST_TOKWAIT;
               end else begin
                  seq_phase = ST_GAP; seq_index = 0;
               end
            end
            ST_GAP: begin
               seq_index++;
               r.send_valid = 1'b1; r.mosi_byte = sdh_pkg::BYTE_IDLE;
               if (seq_index >= 3) begin
                  seq_phase = ST_WTOKEN;
                  r.mosi_byte = (seq_op == sdh_pkg::OP_WRITE) ?
                                sdh_pkg::TOK_SINGLE : sdh_pkg::TOK_MULTI;
               end
            end
            ST_WTOKEN: begin
               seq_phase = ST_WPAYREQ; seq_index = 0; r.need_payload = 1'b1;
            end
            ST_WPAYSENT: begin
               seq_index++;
               if (seq_index < sdh_pkg::BLOCK_BYTES) begin
                  seq_phase = ST_WPAYREQ; r.need_payload = 1'b1;
               end else begin
                  seq_phase = ST_DRESP; r.send_valid = 1'b1;
                  r.mosi_byte = sdh_pkg::BYTE_IDLE;
               end
            end
            ST_DRESP: begin
               if ((card & sdh_pkg::DRESP_MASK) == sdh_pkg::DRESP_OK) seq_phase = ST_BUSY;
               r.send_valid = 1'b1; r.mosi_byte = sdh_pkg::BYTE_IDLE;
            end
            ST_BUSY: begin
               if (card == sdh_pkg::BYTE_BUSY) begin
                  r.send_valid = 1'b1; r.mosi_byte = sdh_pkg::BYTE_IDLE;
               end else if (seq_op == sdh_pkg::OP_WRITE) begin
                  seq_phase = ST_IDLE; r.done_res = 1'b1;
               end else begin
                  if (seq_blocks > 0) seq_blocks--;
                  r.send_valid = 1'b1;
                  if (seq_blocks > 0) begin
                     seq_phase = ST_WTOKEN; r.mosi_byte = sdh_pkg::TOK_MULTI;
                  end else begin
                     seq_phase = ST_STOP; r.mosi_byte = sdh_pkg::TOK_STOP;
                  end
               end
            end
            ST_STOP: begin
               seq_phase = ST_STOPBUSY; r.send_valid = 1'b1;
               r.mosi_byte = sdh_pkg::BYTE_IDLE;
            end
            ST_STOPBUSY: begin
               if (card == sdh_pkg::BYTE_BUSY) begin
                  r.send_valid = 1'b1; r.mosi_byte = sdh_pkg::BYTE_IDLE;
               end else begin
                  seq_phase = ST_IDLE; r.done_res = 1'b1;
               end
            end
            ST_TOKWAIT: begin
               if (card == sdh_pkg::TOK_SINGLE) begin
                  seq_phase = ST_RDATA; seq_index = 0;
               end
               r.send_valid = 1'b1; r.mosi_byte = sdh_pkg::BYTE_IDLE;
            end
            ST_RDATA: begin
               if (seq_op == sdh_pkg::OP_READ) begin
                  r.read_valid = 1'b1; r.read_byte = card; lim = sdh_pkg::BLOCK_BYTES;
               end else begin
                  if (seq_index < sdh_pkg::CSD_LEN) csd_shadow[seq_index] = card;
                  lim = sdh_pkg::CSD_LEN;
               end
               seq_index++;
               if (seq_index >= lim) begin
                  seq_phase = ST_TRAIL; seq_index = 0;
               end
               r.send_valid = 1'b1; r.mosi_byte = sdh_pkg::BYTE_IDLE;
            end
            ST_TRAIL: begin
               seq_index++;
               lim = (seq_op == sdh_pkg::OP_READ) ? 3 : 10;
               if (seq_index < lim) begin
                  r.send_valid = 1'b1; r.mosi_byte = sdh_pkg::BYTE_IDLE;
               end else begin
                  seq_phase = ST_IDLE; r.done_res = 1'b1;
                  if (seq_op == sdh_pkg::OP_CAP) r.capacity = csd_capacity();
               end
            end
            default: return 0;
         endcase
      end else begin
         return 0;
      end
      r.fast_clock = fast_sel;
      return 1;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      if (fail_count <= 40)
         $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
   endtask

   // drive one item, hold until accepted, then predict its result
   task automatic send_item(input sdh_pkg::req_type it);
      bit               taken;
      sdh_pkg::rsp_type r;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      items_sent++;
      if (predict_step(it, r)) expected_beats.push_back(r);
   endtask

   // drop valid and wait for every expected beat plus the pipeline tail
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= wr;
      csr_paddr <= sdh_pkg::REG_WAIT_LIMIT; csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      rdata = csr_prdata;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_wait_limit(input logic [7:0] value);
      logic [31:0] rd;
      csr_access(1'b1, {24'd0, value}, rd);
      wait_limit = value;
      csr_access(1'b0, 32'd0, rd);
      if (rd[7:0] != value) report_mismatch("wait limit readback", rd, {24'd0, value});
   endtask

   // pick the next item from the predicted state, biased toward progress
   function automatic sdh_pkg::req_type next_item();
      sdh_pkg::req_type it;
      int               roll;
      it = REQ_W'({$urandom, $urandom});
      roll = $urandom_range(99);
      if ($urandom_range(99) < noise_pct) begin
         if (it.kind == sdh_pkg::KIND_START && it.op == sdh_pkg::OP_MULTI)
            it.block_count = 8'($urandom_range(2, 1));
         return it;
      end
      if (seq_phase == ST_WPAYREQ) begin
         it.kind = sdh_pkg::KIND_PAYLOAD;
         return it;
      end
      it.kind = sdh_pkg::KIND_CARD;
      case (seq_phase)
         ST_POLL:
            if (roll < 70)
               it.miso_byte = (seq_op == sdh_pkg::OP_INIT && seq_stage == 0) ?
                              sdh_pkg::R1_IDLE : sdh_pkg::R1_READY;
            else if (roll < 85)
               it.miso_byte = sdh_pkg::BYTE_IDLE;
         ST_TOKWAIT: if (roll < 75) it.miso_byte = sdh_pkg::TOK_SINGLE;
         ST_DRESP:
            if (roll < 80) it.miso_byte = {it.miso_byte[7:5], sdh_pkg::DRESP_OK[4:0]};
         ST_BUSY, ST_STOPBUSY: if (roll < 60) it.miso_byte = sdh_pkg::BYTE_BUSY;
         default: ;
      endcase
      return it;
   endfunction

   // run one operation from its start beat until the block is idle again
   task automatic run_op(input logic [2:0] op, input logic [22:0] sector,
                         input logic [7:0] count, input bit poke_busy);
      sdh_pkg::req_type it;
      it = REQ_W'({$urandom, $urandom});
      it.kind = sdh_pkg::KIND_START; it.op = op; it.sector = sector;
      it.block_count = count;
      send_item(it);
      if (poke_busy) begin
         it.op = sdh_pkg::OP_READ;
         send_item(it);
      end
      while (seq_phase != ST_IDLE) send_item(next_item());
   endtask

   task automatic test_operations();
      run_op(sdh_pkg::OP_INIT, 23'd0, 8'hFF, 1'b1);
      run_op(sdh_pkg::OP_CAP, 23'h7FFFFF, 8'h00, 1'b1);
      run_op(sdh_pkg::OP_MULTI, 23'h2AAAAA, 8'd1, 1'b0);
      drain();
   endtask

   task automatic test_ignored_items();
      sdh_pkg::req_type it;
      it = '0;
      for (int k = 5; k <= 7; k++) begin
         it.kind = sdh_pkg::KIND_START; it.op = k[2:0];
         send_item(it);
      end
      it.op = sdh_pkg::OP_INIT;
      it.kind = sdh_pkg::KIND_CARD;    send_item(it);
      it.kind = sdh_pkg::KIND_PAYLOAD; send_item(it);
      it.kind = 2'd3;                  send_item(it);
      drain();
   endtask

   // a single poll and a zero limit both force reissue on an idle byte
   task automatic test_poll_limit();
      noise_pct = 0;
      set_wait_limit(8'd1);
      run_op(sdh_pkg::OP_INIT, 23'd0, 8'd0, 1'b0);
      run_op(sdh_pkg::OP_CAP, 23'd0, 8'd1, 1'b0);
      drain();
      set_wait_limit(8'd0);
      run_op(sdh_pkg::OP_INIT, 23'h1, 8'd1, 1'b0);
      drain();
      set_wait_limit(8'd255);
      run_op(sdh_pkg::OP_READ, 23'h3, 8'd1, 1'b0);
      drain();
   endtask

   task automatic test_random_phase(input int sender_idle, input int receiver_stall,
                                    input logic [7:0] limit, input bit pause_once);
      int stop_at;
      int roll;
      bit hold_once;
      hold_once = pause_once;
      set_wait_limit(limit);
      idle_pct = sender_idle; stall_pct = receiver_stall; noise_pct = 4;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         roll = $urandom_range(99);
         if (roll < 50) run_op(sdh_pkg::OP_INIT, 23'($urandom), 8'($urandom), 1'b0);
         else run_op(sdh_pkg::OP_CAP, 23'($urandom), 8'($urandom), roll[0]);
         // hold the sender until every outstanding beat is back
         if (hold_once) begin
            drain();
            hold_once = 1'b0;
         end
         // stray beats between operations
         if ($urandom_range(9) == 0) send_item(next_item());
      end
      drain();
   endtask

   // random receiver stall
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   // compare each accepted result beat with the oldest prediction
   always @(negedge clock) begin
      sdh_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("unexpected result beat", {24'd0, rsp_data.mosi_byte}, 32'd0);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_data.send_valid !== want.send_valid)
               report_mismatch("send_valid", rsp_data.send_valid, want.send_valid);
            if (rsp_data.mosi_byte !== want.mosi_byte)
               report_mismatch("mosi_byte", rsp_data.mosi_byte, want.mosi_byte);
            if (rsp_data.need_payload !== want.need_payload)
               report_mismatch("need_payload", rsp_data.need_payload, want.need_payload);
            if (rsp_data.read_valid !== want.read_valid)
               report_mismatch("read_valid", rsp_data.read_valid, want.read_valid);
            if (rsp_data.read_byte !== want.read_byte)
               report_mismatch("read_byte", rsp_data.read_byte, want.read_byte);
            if (rsp_data.fast_clock !== want.fast_clock)
               report_mismatch("fast_clock", rsp_data.fast_clock, want.fast_clock);
            if (rsp_data.capacity !== want.capacity)
               report_mismatch("capacity", rsp_data.capacity, want.capacity);
            if (rsp_data.done_res !== want.done_res)
               report_mismatch("done_res", rsp_data.done_res, want.done_res);
         end
      end
   end

   // watchdog: count cycles with no beat on either channel
   always @(negedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_wait_limit(sdh_pkg::WAIT_LIMIT_RST);
      test_operations();
      test_ignored_items();
      test_poll_limit();
      test_random_phase(0, 0, 8'd100, 1'b0);
      test_random_phase(82, 0, 8'd255, 1'b1);
      test_random_phase(0, 82, 8'd1, 1'b0);
      test_random_phase(15, 15, 8'($urandom_range(255, 2)), 1'b0);
      drain();
      if (expected_beats.size() != 0)
         report_mismatch("results left over", expected_beats.size(), 32'd0);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
